// ===== sv/cfb_pkg.sv =====
// Package: shared types, constants and checksum helper for the command frame builder.
`timescale 1ns / 1ps

package cfb_pkg;

  // Operation codes of an input item
  localparam logic OP_HEADER  = 1'b0;
  localparam logic OP_PAYLOAD = 1'b1;

  // Register indexes on the configuration port
  localparam logic REG_START_CODE = 1'b0;
  localparam logic REG_END_CODE   = 1'b1;

  // Byte positions of the back-end sequencer
  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] STEP_START  = 4'd0;
  localparam logic [STEP_W-1:0] STEP_LEN3   = 4'd1;
  localparam logic [STEP_W-1:0] STEP_LEN2   = 4'd2;
  localparam logic [STEP_W-1:0] STEP_LEN1   = 4'd3;
  localparam logic [STEP_W-1:0] STEP_LEN0   = 4'd4;
  localparam logic [STEP_W-1:0] STEP_CMD_HI = 4'd5;
  localparam logic [STEP_W-1:0] STEP_CMD_LO = 4'd6;
  localparam logic [STEP_W-1:0] STEP_BODY   = 4'd7;  // device byte or payload byte
  localparam logic [STEP_W-1:0] STEP_CK_HI  = 4'd8;
  localparam logic [STEP_W-1:0] STEP_CK_LO  = 4'd9;
  localparam logic [STEP_W-1:0] STEP_END    = 4'd10;

  // Queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);

  // One classified item handed to the back end
  typedef struct packed {
    logic        op;
    logic [15:0] cmd;
    logic [7:0]  dev;
    logic [23:0] len;
    logic [7:0]  data;
    logic        close;    // this item ends the frame
    logic [15:0] ck_sum;   // running sum before the final word
    logic [15:0] ck_word;  // final word still to be folded in
  } qent_t;

  // Ones'-complement 16-bit add with end-around carry
  function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    logic [16:0] f;
    s = {1'b0, a} + {1'b0, b};
    f = {1'b0, s[15:0]} + {16'd0, s[16]};
    return f[15:0];
  endfunction

endpackage

// ===== sv/command_frame_builder_with_checksum.sv =====
// Top level: command frame builder with a ones'-complement checksum.
//
// Items enter on the item channel (item_valid/item_ready). A header item
// (operation 0) yields the start code, a 4-byte big-endian length, the
// command word and device byte; if its length is zero it also yields the
// checksum (high byte first) and the end code. A payload item (operation 1)
// yields its byte, and the final payload byte of a frame adds checksum and
// end code. Payload outside a frame is consumed with no output.
// Bytes leave on the byte channel (byte_valid/byte_ready), last_byte set on
// the end code. The front end takes one item per cycle while its two-entry
// queue has room; the back end sends one byte per cycle while the receiver
// is ready, so a header item yields 8 or 11 bytes and a payload item 1 or 4.
// An item goes through queue and current-item register to the output.
// When the receiver stalls, the output register holds its byte and the
// queue fills; item_ready then drops. Reset clears frame state, queue and
// output; start_code and end_code (APB, addresses 0 and 4) reset to zero.
`timescale 1ns / 1ps

module command_frame_builder_with_checksum (
  input  logic        clk,
  input  logic        rst,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // item channel
  input  logic        item_valid,
  output logic        item_ready,
  input  logic        operation,
  input  logic [15:0] command_code,
  input  logic [7:0]  device_number,
  input  logic [23:0] payload_length,
  input  logic [7:0]  data_byte,
  // byte channel
  output logic        byte_valid,
  input  logic        byte_ready,
  output logic [7:0]  frame_byte,
  output logic        last_byte
);
  import cfb_pkg::*;

  logic [7:0] start_code;
  logic [7:0] end_code;
  logic       cfg_wr;

  logic       q_push, q_pop, q_full, q_empty;
  qent_t      q_wdata, q_rdata;

  // Configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_code <= 8'd0;
      end_code   <= 8'd0;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_START_CODE) begin
        start_code <= pwdata[7:0];
      end else begin
        end_code <= pwdata[7:0];
      end
    end
  end

  assign prdata = {24'd0, (paddr[2] == REG_END_CODE) ? end_code : start_code};

  cfb_front u_front (
    .clk            (clk),
    .rst            (rst),
    .item_valid     (item_valid),
    .item_ready     (item_ready),
    .operation      (operation),
    .command_code   (command_code),
    .device_number  (device_number),
    .payload_length (payload_length),
    .data_byte      (data_byte),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_wdata        (q_wdata)
  );

  cfb_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  cfb_back u_back (
    .clk        (clk),
    .rst        (rst),
    .start_code (start_code),
    .end_code   (end_code),
    .q_empty    (q_empty),
    .q_rdata    (q_rdata),
    .q_pop      (q_pop),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .frame_byte (frame_byte),
    .last_byte  (last_byte)
  );

endmodule

// ===== sv/cfb_front.sv =====
// Front end: accepts items, tracks frame state and the running checksum.
`timescale 1ns / 1ps

module cfb_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  input  logic               operation,
  input  logic [15:0]        command_code,
  input  logic [7:0]         device_number,
  input  logic [23:0]        payload_length,
  input  logic [7:0]         data_byte,
  input  logic               q_full,
  output logic               q_push,
  output cfb_pkg::qent_t     q_wdata
);
  import cfb_pkg::*;

  logic        in_frame, in_frame_next;
  logic [23:0] remaining, remaining_next;
  logic [15:0] sum, sum_next;
  logic        pending, pending_next;
  logic [7:0]  held, held_next;

  logic        accept;
  logic [15:0] hdr_sum;
  logic        close;

  assign item_ready = !q_full;
  assign accept     = item_valid && item_ready;

  // Header words: {len hi, 0}, {len lo, len mid}, {cmd lo, cmd hi}; device byte left pending
  assign hdr_sum = oc_add(oc_add({payload_length[23:16], 8'h00},
                                 {payload_length[7:0], payload_length[15:8]}),
                          {command_code[7:0], command_code[15:8]});

  // Classify and update frame state
  always_comb begin
    in_frame_next  = in_frame;
    remaining_next = remaining;
    sum_next       = sum;
    pending_next   = pending;
    held_next      = held;
    close          = 1'b0;
    q_push         = 1'b0;
    q_wdata.op      = operation;
    q_wdata.cmd     = command_code;
    q_wdata.dev     = device_number;
    q_wdata.len     = payload_length;
    q_wdata.data    = data_byte;
    q_wdata.ck_sum  = hdr_sum;
    q_wdata.ck_word = {8'h00, device_number};
    if (accept) begin
      if (operation == OP_HEADER) begin
        q_push = 1'b1;
        close  = (payload_length == 24'd0);
        if (close) begin
          in_frame_next  = 1'b0;
          remaining_next = 24'd0;
          sum_next       = 16'd0;
          pending_next   = 1'b0;
          held_next      = 8'd0;
        end else begin
          in_frame_next  = 1'b1;
          remaining_next = payload_length;
          sum_next       = hdr_sum;
          pending_next   = 1'b1;
          held_next      = device_number;
        end
      end else if (in_frame) begin
        q_push          = 1'b1;
        close           = (remaining == 24'd1);
        q_wdata.ck_sum  = sum;
        q_wdata.ck_word = pending ? {data_byte, held} : {8'h00, data_byte};
        remaining_next  = remaining - 24'd1;
        if (close) begin
          in_frame_next = 1'b0;
          sum_next      = 16'd0;
          pending_next  = 1'b0;
          held_next     = 8'd0;
        end else if (pending) begin
          sum_next     = oc_add(sum, {data_byte, held});
          pending_next = 1'b0;
        end else begin
          held_next    = data_byte;
          pending_next = 1'b1;
        end
      end
    end
    q_wdata.close = close;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame  <= 1'b0;
      remaining <= 24'd0;
      sum       <= 16'd0;
      pending   <= 1'b0;
      held      <= 8'd0;
    end else begin
      in_frame  <= in_frame_next;
      remaining <= remaining_next;
      sum       <= sum_next;
      pending   <= pending_next;
      held      <= held_next;
    end
  end

endmodule

// ===== sv/cfb_queue.sv =====
// Small register FIFO between front end and back end.
`timescale 1ns / 1ps

module cfb_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  cfb_pkg::qent_t wdata,
  output logic           full,
  input  logic           pop,
  output cfb_pkg::qent_t rdata,
  output logic           empty
);
  import cfb_pkg::*;

  qent_t             mem [QDEPTH];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  logic [QPTR_W:0]   count;

  assign full  = (count == (QPTR_W+1)'(QDEPTH));
  assign empty = (count == '0);
  assign rdata = mem[rptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= wdata;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == QPTR_W'(QDEPTH-1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == QPTR_W'(QDEPTH-1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== sv/cfb_back.sv =====
// Back end: sequences frame bytes of each queued item into the output register.
`timescale 1ns / 1ps

module cfb_back (
  input  logic           clk,
  input  logic           rst,
  input  logic [7:0]     start_code,
  input  logic [7:0]     end_code,
  input  logic           q_empty,
  input  cfb_pkg::qent_t q_rdata,
  output logic           q_pop,
  output logic           byte_valid,
  input  logic           byte_ready,
  output logic [7:0]     frame_byte,
  output logic           last_byte
);
  import cfb_pkg::*;

  qent_t             cur;
  logic              cur_valid;
  logic [STEP_W-1:0] step;
  logic [15:0]       ck;

  logic              adv;
  logic              last_step;
  logic [7:0]        byte_sel;

  assign adv       = cur_valid && (!byte_valid || byte_ready);
  assign last_step = cur.close ? (step == STEP_END) : (step == STEP_BODY);
  assign q_pop     = !q_empty && (!cur_valid || (adv && last_step));

  // Byte for the current position
  always_comb begin
    case (step)
      STEP_START:  byte_sel = start_code;
      STEP_LEN3:   byte_sel = 8'h00;
      STEP_LEN2:   byte_sel = cur.len[23:16];
      STEP_LEN1:   byte_sel = cur.len[15:8];
      STEP_LEN0:   byte_sel = cur.len[7:0];
      STEP_CMD_HI: byte_sel = cur.cmd[15:8];
      STEP_CMD_LO: byte_sel = cur.cmd[7:0];
      STEP_BODY:   byte_sel = (cur.op == OP_PAYLOAD) ? cur.data : cur.dev;
      STEP_CK_HI:  byte_sel = ck[15:8];
      STEP_CK_LO:  byte_sel = ck[7:0];
      STEP_END:    byte_sel = end_code;
      default:     byte_sel = 8'h00;
    endcase
  end

  // Current item and position; checksum finished as the item is loaded
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      step      <= STEP_START;
    end else if (q_pop) begin
      cur_valid <= 1'b1;
      step      <= (q_rdata.op == OP_PAYLOAD) ? STEP_BODY : STEP_START;
    end else if (adv) begin
      if (last_step) begin
        cur_valid <= 1'b0;
      end else begin
        step <= step + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_rdata;
      ck  <= ~oc_add(q_rdata.ck_sum, q_rdata.ck_word);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (adv) begin
      byte_valid <= 1'b1;
    end else if (byte_ready) begin
      byte_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      frame_byte <= byte_sel;
      last_byte  <= (step == STEP_END);
    end
  end

endmodule

// ===== tb/cfb_frame_checker.sv =====
// Checker for the command frame builder: predicts the byte stream and compares every transfer.
`timescale 1ns / 1ps

module cfb_frame_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  input  logic        item_valid,
  input  logic        item_ready,
  input  logic        operation,
  input  logic [15:0] command_code,
  input  logic [7:0]  device_number,
  input  logic [23:0] payload_length,
  input  logic [7:0]  data_byte,
  input  logic        byte_valid,
  input  logic        byte_ready,
  input  logic [7:0]  frame_byte,
  input  logic        last_byte,
  output int          fail_count,
  output int          backlog
);
  import cfb_pkg::*;

  // One expected byte on the wire
  typedef struct packed {
    logic [7:0] value;
    logic       closes;
  } wire_byte_t;

  wire_byte_t wire_q[$];

  // Local copy of the register file and the framing state
  logic [7:0]  start_reg;
  logic [7:0]  end_reg;
  logic        frame_open;
  logic [23:0] left_count;
  logic [15:0] acc;
  logic        half_held;
  logic [7:0]  low_hold;
  int          mismatches;

  // 16-bit add with end-around carry
  function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] t;
    t = {1'b0, a} + {1'b0, b};
    t = {1'b0, t[15:0]} + {16'd0, t[16]};
    return t[15:0];
  endfunction

  // Pair bytes little-endian into the running sum
  task automatic sum_in(input logic [7:0] b);
    if (!half_held) begin
      low_hold  = b;
      half_held = 1'b1;
    end else begin
      acc       = ones_add(acc, {b, low_hold});
      half_held = 1'b0;
    end
  endtask

  task automatic queue_byte(input logic [7:0] b, input logic closes);
    wire_byte_t e;
    e.value  = b;
    e.closes = closes;
    wire_q.push_back(e);
  endtask

  // Byte that is both sent and covered by the checksum
  task automatic send_summed(input logic [7:0] b);
    queue_byte(b, 1'b0);
    sum_in(b);
  endtask

  // Checksum high then low, then the end code; frame state clears
  task automatic close_out();
    logic [15:0] s;
    logic [15:0] ck;
    s = acc;
    if (half_held)
      s = ones_add(s, {8'h00, low_hold});
    ck = ~s;
    queue_byte(ck[15:8], 1'b0);
    queue_byte(ck[7:0], 1'b0);
    queue_byte(end_reg, 1'b1);
    frame_open = 1'b0;
    left_count = '0;
    acc        = '0;
    half_held  = 1'b0;
    low_hold   = '0;
  endtask

  // Expected bytes for one accepted item
  task automatic predict_item(input logic op, input logic [15:0] cmd, input logic [7:0] dev,
                              input logic [23:0] len, input logic [7:0] data);
    if (op == OP_HEADER) begin
      acc       = '0;
      half_held = 1'b0;
      low_hold  = '0;
      queue_byte(start_reg, 1'b0);
      send_summed(8'h00);
      send_summed(len[23:16]);
      send_summed(len[15:8]);
      send_summed(len[7:0]);
      send_summed(cmd[15:8]);
      send_summed(cmd[7:0]);
      send_summed(dev);
      if (len == '0) begin
        close_out();
      end else begin
        frame_open = 1'b1;
        left_count = len;
      end
    end else if (frame_open) begin
      send_summed(data);
      left_count = left_count - 24'd1;
      if (left_count == '0)
        close_out();
    end
  endtask

  // Watch the register port, the item channel and the byte channel
  always @(posedge clk) begin
    wire_byte_t exp_b;
    if (rst) begin
      start_reg  = '0;
      end_reg    = '0;
      frame_open = 1'b0;
      left_count = '0;
      acc        = '0;
      half_held  = 1'b0;
      low_hold   = '0;
      mismatches = 0;
      wire_q.delete();
      backlog    <= 0;
      fail_count <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr == {REG_START_CODE, 2'b00})
          start_reg = pwdata[7:0];
        else if (paddr == {REG_END_CODE, 2'b00})
          end_reg = pwdata[7:0];
      end

      if (item_valid && item_ready)
        predict_item(operation, command_code, device_number, payload_length, data_byte);

      // Output transfer against the oldest expectation
      if (byte_valid && byte_ready) begin
        if (wire_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected byte transfer: frame_byte=%02h last_byte=%b",
                     $time, frame_byte, last_byte);
        end else begin
          exp_b = wire_q.pop_front();
          if (frame_byte !== exp_b.value || last_byte !== exp_b.closes) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: byte mismatch: frame_byte exp %02h got %02h, last_byte exp %b got %b",
                       $time, exp_b.value, frame_byte, exp_b.closes, last_byte);
          end
        end
      end

      backlog    <= wire_q.size();
      fail_count <= mismatches;
    end
  end

endmodule

// ===== tb/command_frame_builder_with_checksum_tb.sv =====
// Testbench top for the command frame builder: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module command_frame_builder_with_checksum_tb;
  import cfb_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int SETTLE      = 16;
  localparam int PHASE_ITEMS = 80;
  localparam int PHASES      = 5;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        item_valid;
  logic        item_ready;
  logic        operation;
  logic [15:0] command_code;
  logic [7:0]  device_number;
  logic [23:0] payload_length;
  logic [7:0]  data_byte;
  logic        byte_valid;
  logic        byte_ready = 1'b0;
  logic [7:0]  frame_byte;
  logic        last_byte;

  int fail_count;
  int backlog;

  // Stimulus bookkeeping
  int          cycle_count  = 0;
  int          stall_left   = 0;
  int          rx_draw;
  bit          rx_calm      = 1'b0;
  bit          tx_calm      = 1'b0;
  int          bytes_taken  = 0;
  int          items_sent   = 0;
  int          headers_sent = 0;
  int          stray_sent   = 0;
  int          settings     = 1;
  logic [23:0] tb_left      = '0;
  logic [7:0]  start_set [PHASES];
  logic [7:0]  end_set   [PHASES];

  command_frame_builder_with_checksum u_top (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .item_valid     (item_valid),
    .item_ready     (item_ready),
    .operation      (operation),
    .command_code   (command_code),
    .device_number  (device_number),
    .payload_length (payload_length),
    .data_byte      (data_byte),
    .byte_valid     (byte_valid),
    .byte_ready     (byte_ready),
    .frame_byte     (frame_byte),
    .last_byte      (last_byte)
  );

  cfb_frame_checker u_chk (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .pready         (pready),
    .item_valid     (item_valid),
    .item_ready     (item_ready),
    .operation      (operation),
    .command_code   (command_code),
    .device_number  (device_number),
    .payload_length (payload_length),
    .data_byte      (data_byte),
    .byte_valid     (byte_valid),
    .byte_ready     (byte_ready),
    .frame_byte     (frame_byte),
    .last_byte      (last_byte),
    .fail_count     (fail_count),
    .backlog        (backlog)
  );

  // 12 ns clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d bytes still expected", cycle_count, backlog);
      $display("command_frame_builder_with_checksum_tb failed");
      $finish;
    end
  end

  // Receiver: after each transfer draw a stall, with calm stretches of none
  always @(posedge clk) begin
    if (rst) begin
      byte_ready <= 1'b0;
      stall_left <= 0;
    end else begin
      if (byte_valid && byte_ready)
        bytes_taken <= bytes_taken + 1;
      if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        byte_ready <= (stall_left == 1);
      end else if (byte_valid && byte_ready) begin
        if ($urandom_range(0, 19) == 0)
          rx_calm <= !rx_calm;
        rx_draw = rx_calm ? 0 : $urandom_range(0, 18);
        stall_left <= rx_draw;
        byte_ready <= (rx_draw == 0);
      end else begin
        byte_ready <= 1'b1;
      end
    end
  end

  // One item transfer; called at a clock edge, returns at the accepting edge
  task automatic push_item(input logic op, input logic [15:0] cmd, input logic [7:0] dev,
                           input logic [23:0] len, input logic [7:0] data);
    int gap;
    if ($urandom_range(0, 15) == 0)
      tx_calm = !tx_calm;
    gap = tx_calm ? 0 : $urandom_range(0, 18);
    if (gap != 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid     <= 1'b1;
    operation      <= op;
    command_code   <= cmd;
    device_number  <= dev;
    payload_length <= len;
    data_byte      <= data;
    do @(posedge clk); while (!item_ready);
  endtask

  // Header; unused data byte is random
  task automatic send_header(input logic [15:0] cmd, input logic [7:0] dev,
                             input logic [23:0] len);
    push_item(OP_HEADER, cmd, dev, len, 8'($urandom_range(0, 255)));
    tb_left = len;
    items_sent++;
    headers_sent++;
  endtask

  // Payload byte; header fields carry noise, bytes outside a frame are dropped
  task automatic send_payload(input logic [7:0] data);
    push_item(OP_PAYLOAD, 16'($urandom_range(0, 16'hffff)), 8'($urandom_range(0, 255)),
              24'($urandom_range(0, 24'hffffff)), data);
    if (tb_left != 0) begin
      tb_left = tb_left - 24'd1;
      items_sent++;
    end else begin
      stray_sent++;
    end
  endtask

  // Register write: setup then access cycle
  task automatic write_reg(input logic idx, input logic [7:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'h0, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Drain: every expected byte out, then let dropped items clear the block
  task automatic settle();
    item_valid <= 1'b0;
    do @(posedge clk); while (backlog != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Frames of random content; some are cut short, some followed by stray bytes
  task automatic run_random(input int target);
    int          pick;
    int          cut;
    logic [23:0] len;
    int          stop_at;
    stop_at = items_sent + target;
    while (items_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        // huge length: a few bytes, then the next header abandons it
        send_header(16'($urandom_range(0, 16'hffff)), 8'($urandom_range(0, 255)),
                    24'($urandom_range(0, 24'hffffff)));
        repeat ($urandom_range(0, 4)) send_payload(8'($urandom_range(0, 255)));
      end else begin
        len = (pick < 80) ? 24'($urandom_range(0, 9)) : 24'($urandom_range(10, 40));
        cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, len) : len;
        send_header(16'($urandom_range(0, 16'hffff)), 8'($urandom_range(0, 255)), len);
        repeat (cut) send_payload(8'($urandom_range(0, 255)));
      end
      if (tb_left == 0 && $urandom_range(0, 9) == 0)
        repeat ($urandom_range(1, 3)) send_payload(8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    rst            = 1'b1;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    item_valid     = 1'b0;
    operation      = OP_HEADER;
    command_code   = '0;
    device_number  = '0;
    payload_length = '0;
    data_byte      = '0;

    start_set[0] = 8'hff; end_set[0] = 8'h00;
    start_set[1] = 8'h00; end_set[1] = 8'hff;
    start_set[2] = 8'hff; end_set[2] = 8'hff;
    start_set[3] = 8'($urandom_range(0, 255)); end_set[3] = 8'($urandom_range(0, 255));
    start_set[4] = 8'($urandom_range(0, 255)); end_set[4] = 8'($urandom_range(0, 255));

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: codes at reset values
    send_payload(8'hff);                      // outside any frame, dropped
    send_header(16'h0000, 8'h00, 24'h000000); // empty frame closes at once
    send_header(16'hffff, 8'hff, 24'h000000);
    send_header(16'h1234, 8'h5a, 24'h000001); // single byte, pairs with the device byte
    send_payload(8'hff);
    send_header(16'h8001, 8'h01, 24'h000002);
    send_payload(8'h00);
    send_payload(8'hff);
    send_header(16'habcd, 8'h80, 24'hffffff); // longest length, left open
    repeat (3) send_payload(8'hff);
    send_header(16'h0f0f, 8'h3c, 24'h000003); // abandons the open frame
    send_payload(8'h80);
    send_payload(8'h7f);
    send_payload(8'h01);
    send_payload(8'h00);                      // dropped again
    send_header(16'h5555, 8'haa, 24'h7ffffe);
    send_payload(8'h12);
    send_header(16'hffff, 8'hff, 24'h000005); // carry-heavy sum
    repeat (5) send_payload(8'hff);
    settle();

    // Random phases, each under its own register setting
    for (int ph = 0; ph < PHASES; ph++) begin
      write_reg(REG_START_CODE, start_set[ph]);
      write_reg(REG_END_CODE, end_set[ph]);
      settings++;
      run_random(PHASE_ITEMS);
      settle();
    end

    $display("run covered %0d items (%0d headers) and %0d dropped stray bytes",
             items_sent, headers_sent, stray_sent);
    $display("%0d output byte transfers checked under %0d register settings",
             bytes_taken, settings);
    if (fail_count == 0 && backlog == 0) begin
      $display("command_frame_builder_with_checksum_tb passed");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("command_frame_builder_with_checksum_tb failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/cfb_pkg.sv
sv/cfb_front.sv
sv/cfb_queue.sv
sv/cfb_back.sv
sv/command_frame_builder_with_checksum.sv
tb/cfb_frame_checker.sv
tb/command_frame_builder_with_checksum_tb.sv
